// File: hw/rtl/spr_pkg.sv
// Shared types and constants for the slotted page row store.
// Used by spr_ctrl, spr_dpath and slotted_page_row_store_top.
package spr_pkg;

  localparam int unsigned PAGE_BYTES_DEF = 4096;
  localparam int unsigned MAX_SLOTS_DEF  = 1024;
  localparam int unsigned HDR_BYTES      = 24;
  localparam int unsigned ENTRY_BYTES    = 4;
  localparam int unsigned LEN_W          = 12;
  localparam int unsigned RUN_CNT_W      = 13;
  localparam int unsigned WORK_W         = 18;

  typedef enum logic [2:0] {
    OP_INIT   = 3'd0,
    OP_INSERT = 3'd1,
    OP_READ   = 3'd2,
    OP_DELETE = 3'd3,
    OP_UPDATE = 3'd4,
    OP_LINK   = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_SPACE = 3'd1,
    ST_BAD_SLOT = 3'd2,
    ST_DELETED  = 3'd3,
    ST_BOUNDS   = 3'd4,
    ST_MISMATCH = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FIN
  } state_e;

  typedef struct packed {
    logic accept;
    logic exec;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic has_result;
  } dp_stat_t;

endpackage

// File: hw/rtl/spr_ctrl.sv
// Sequencer for the slotted page row store: accept, execute, finish.
// Depends on spr_pkg; drives spr_dpath through ctrl_cmd_t.
module spr_ctrl import spr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_EXEC;
      S_EXEC: state_d = S_FIN;
      S_FIN: begin
        if (!stat_i.has_result || !out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.accept = (state_q == S_IDLE) && in_valid_i;
    cmd_o.exec   = (state_q == S_EXEC);
    cmd_o.load   = (state_q == S_FIN) && stat_i.has_result && (!out_valid_q || out_ready_i);
    in_ready_o   = (state_q == S_IDLE);
    out_valid_d  = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.load) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (!out_valid_q || out_ready_i)) else $error("load over pending result");
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == S_EXEC)) else $error("accept not followed by exec");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !cmd_o.accept) else $error("accept while busy");

endmodule

// File: hw/rtl/spr_dpath.sv
// Datapath of the slotted page row store: item registers, slot table,
// row store, page allocation state and result registers. Uses spr_pkg.
module spr_dpath import spr_pkg::*; #(
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF,
  parameter int unsigned MAX_SLOTS  = MAX_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_cmd_t   cmd_i,
  output dp_stat_t    stat_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  input  logic [2:0]  operation_i,
  input  logic [9:0]  slot_id_i,
  input  logic [11:0] row_length_i,
  input  logic [11:0] byte_index_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  input  logic [31:0] link_value_i,
  output logic [2:0]  status_o,
  output logic [9:0]  new_slot_o,
  output logic [7:0]  read_byte_o,
  output logic [11:0] stored_length_o,
  output logic [9:0]  slot_total_o,
  output logic [11:0] free_bytes_o,
  output logic [31:0] next_link_o,
  output logic [31:0] this_page_o
);

  localparam int unsigned PW  = $clog2(PAGE_BYTES + 1);
  localparam int unsigned AW  = $clog2(PAGE_BYTES);
  localparam int unsigned SAW = $clog2(MAX_SLOTS);
  localparam int unsigned CW  = $clog2(MAX_SLOTS + 1);
  localparam int unsigned EW  = PW + LEN_W;

  // memories
  logic [EW-1:0] slot_tab [MAX_SLOTS];
  logic [7:0]    row_mem  [PAGE_BYTES];
  logic [EW-1:0] entry_q;
  logic [7:0]    row_q;

  // item registers
  logic [2:0]  op_q;
  logic [9:0]  slot_q;
  logic [11:0] len_q, idx_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic [31:0] link_q, page_id_q;

  // page and run state
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [PW-1:0]        fs_q, fs_d, fe_q, fe_d;
  logic [31:0]          next_q, next_d;
  logic                 busy_q, busy_d, upd_q, upd_d, acc_q, acc_d;
  logic [2:0]           code_q, code_d;
  logic [PW-1:0]        base_q, base_d;
  logic [RUN_CNT_W-1:0] rcnt_q, rcnt_d;
  logic [LEN_W-1:0]     rlen_q, rlen_d, rslen_q, rslen_d;
  logic [SAW-1:0]       rslot_q, rslot_d;

  // pending result
  logic        has_q, has_d, rdok_q, rdok_d;
  logic [2:0]  rst_q, rst_d;
  logic [9:0]  nslot_q, nslot_d;
  logic [11:0] slen_q, slen_d;

  // memory ports
  logic            st_we, rs_we, rs_re;
  logic [SAW-1:0]  st_wa;
  logic [EW-1:0]   st_wd;
  logic [AW-1:0]   rs_a;
  logic [15:0]     slot_in_w;

  assign slot_in_w = 16'(slot_id_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) entry_q <= slot_tab[slot_in_w[SAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (st_we) slot_tab[st_wa] <= st_wd;
  end

  always_ff @(posedge clk_i) begin
    if (rs_we) row_mem[rs_a] <= byte_q;
    else if (rs_re) row_q <= row_mem[rs_a];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= operation_i;
      slot_q <= slot_id_i;
      len_q  <= row_length_i;
      idx_q  <= byte_index_i;
      byte_q <= data_byte_i;
      last_q <= last_i;
      link_q <= link_value_i;
    end
  end

  always_comb begin
    logic [WORK_W-1:0] w_slot, w_cnt, w_fs, w_fe, w_len, w_off, w_size, w_a, w_diff;
    logic [PW-1:0]        e_off;
    logic [LEN_W-1:0]     e_size;
    logic                 is_run, upd, start, slot_ok, ins_fail;
    logic [2:0]           ecode;
    logic [PW-1:0]        ebase;
    logic [RUN_CNT_W-1:0] ecnt, ncnt;
    logic [LEN_W-1:0]     elen, eslen;
    logic [SAW-1:0]       eslot;
    logic                 eacc;
    logic [2:0]           fstat;

    cnt_d = cnt_q; fs_d = fs_q; fe_d = fe_q; next_d = next_q;
    busy_d = busy_q; upd_d = upd_q; acc_d = acc_q; code_d = code_q;
    base_d = base_q; rcnt_d = rcnt_q; rlen_d = rlen_q; rslen_d = rslen_q;
    rslot_d = rslot_q;
    has_d = has_q; rdok_d = rdok_q; rst_d = rst_q; nslot_d = nslot_q; slen_d = slen_q;
    st_we = 1'b0; st_wa = '0; st_wd = '0;
    rs_we = 1'b0; rs_re = 1'b0; rs_a = '0;

    e_off  = entry_q[PW-1:0];
    e_size = entry_q[EW-1:PW];
    w_slot = WORK_W'(slot_q);
    w_cnt  = WORK_W'(cnt_q);
    w_fs   = WORK_W'(fs_q);
    w_fe   = WORK_W'(fe_q);
    w_len  = WORK_W'(len_q);
    w_off  = WORK_W'(e_off);
    w_size = WORK_W'(e_size);
    w_diff = w_fe - w_fs;
    slot_ok = (w_slot < w_cnt) && (w_slot < WORK_W'(MAX_SLOTS));
    ins_fail = (w_fs > w_fe) || (w_len + WORK_W'(ENTRY_BYTES) > w_diff)
               || (w_cnt >= WORK_W'(MAX_SLOTS));
    is_run = (op_q == OP_INSERT) || (op_q == OP_UPDATE);
    upd    = (op_q == OP_UPDATE);
    start  = is_run && !(busy_q && (upd_q == upd));

    ecode = code_q; ebase = base_q; ecnt = rcnt_q; elen = rlen_q;
    eslen = rslen_q; eslot = rslot_q; eacc = acc_q;
    if (start) begin
      ecnt = '0; elen = len_q; eslot = slot_q[SAW-1:0]; ebase = '0; ecode = ST_OK;
      eslen = '0;
      if (!upd) begin
        if (ins_fail) ecode = ST_NO_SPACE;
        else begin
          ebase = PW'(w_fe - w_len);
          eslot = cnt_q[SAW-1:0];
        end
      end else begin
        if (slot_ok) eslen = e_size;
        if (!slot_ok) ecode = ST_BAD_SLOT;
        else if (e_size == '0) ecode = ST_DELETED;
        else if ((w_off + w_size > WORK_W'(PAGE_BYTES)) || (w_off < w_fe)) ecode = ST_BOUNDS;
        else if (len_q != e_size) ecode = ST_MISMATCH;
        else ebase = e_off;
      end
      eacc = (ecode == ST_OK);
    end
    ncnt = (ecnt == '1) ? ecnt : ecnt + 1'b1;
    w_a = WORK_W'(ebase) + WORK_W'(ecnt);
    fstat = ecode;
    if (fstat == ST_OK && WORK_W'(ncnt) < WORK_W'(elen)) fstat = ST_MISMATCH;

    if (cmd_i.exec) begin
      rdok_d = 1'b0; rst_d = ST_OK; nslot_d = '0; slen_d = '0; has_d = 1'b0;
      if (is_run) begin
        if (eacc && WORK_W'(ecnt) < WORK_W'(elen) && w_a < WORK_W'(PAGE_BYTES)) begin
          rs_we = 1'b1;
          rs_a  = w_a[AW-1:0];
        end
        upd_d = upd; code_d = ecode; base_d = ebase; rcnt_d = ncnt; rlen_d = elen;
        rslen_d = eslen; rslot_d = eslot; acc_d = eacc; busy_d = 1'b1;
        if (last_q) begin
          busy_d = 1'b0; acc_d = 1'b0; has_d = 1'b1; rst_d = fstat;
          if (upd) slen_d = eslen;
          else if (fstat == ST_OK) begin
            st_we = 1'b1; st_wa = eslot;
            st_wd = {elen, ebase};
            nslot_d = 10'(eslot);
            slen_d = elen;
            cnt_d = cnt_q + 1'b1;
            fs_d = PW'(w_fs + WORK_W'(ENTRY_BYTES));
            fe_d = PW'(w_fe - WORK_W'(elen));
          end
        end
      end else begin
        busy_d = 1'b0; acc_d = 1'b0;
        case (op_q)
          OP_INIT: begin
            has_d = 1'b1;
            cnt_d = '0; fs_d = PW'(HDR_BYTES); fe_d = PW'(PAGE_BYTES); next_d = '1;
            upd_d = 1'b0; code_d = '0; base_d = '0; rcnt_d = '0; rlen_d = '0;
            rslen_d = '0; rslot_d = '0;
          end
          OP_READ, OP_DELETE: begin
            has_d = 1'b1;
            if (!slot_ok) rst_d = ST_BAD_SLOT;
            else if (e_size == '0) rst_d = ST_DELETED;
            else begin
              slen_d = e_size;
              w_a = w_off + WORK_W'(idx_q);
              if (op_q == OP_READ) begin
                rs_re  = 1'b1;
                rs_a   = w_a[AW-1:0];
                rdok_d = (idx_q < e_size) && (w_a < WORK_W'(PAGE_BYTES));
              end else begin
                st_we = 1'b1; st_wa = slot_q[SAW-1:0];
                st_wd = {{LEN_W{1'b0}}, e_off};
              end
            end
          end
          OP_LINK: begin
            has_d = 1'b1;
            next_d = link_q;
          end
          default: has_d = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; fs_q <= PW'(HDR_BYTES); fe_q <= PW'(PAGE_BYTES); next_q <= '1;
      busy_q <= 1'b0; upd_q <= 1'b0; acc_q <= 1'b0; code_q <= '0; base_q <= '0;
      rcnt_q <= '0; rlen_q <= '0; rslen_q <= '0; rslot_q <= '0;
      has_q <= 1'b0; page_id_q <= '0;
    end else begin
      cnt_q <= cnt_d; fs_q <= fs_d; fe_q <= fe_d; next_q <= next_d;
      busy_q <= busy_d; upd_q <= upd_d; acc_q <= acc_d; code_q <= code_d;
      base_q <= base_d; rcnt_q <= rcnt_d; rlen_q <= rlen_d; rslen_q <= rslen_d;
      rslot_q <= rslot_d; has_q <= has_d;
      if (cfg_we_i) page_id_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdok_q <= rdok_d; rst_q <= rst_d; nslot_q <= nslot_d; slen_q <= slen_d;
  end

  assign stat_o.has_result = has_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_o        <= rst_q;
      new_slot_o      <= nslot_q;
      read_byte_o     <= rdok_q ? row_q : 8'd0;
      stored_length_o <= slen_q;
      slot_total_o    <= 10'(cnt_q);
      free_bytes_o    <= (fe_q >= fs_q) ? 12'(fe_q - fs_q) : 12'd0;
      next_link_o     <= next_q;
      this_page_o     <= page_id_q;
    end
  end

endmodule

// File: hw/rtl/slotted_page_row_store_top.sv
// Top level of the slotted page row store: sequencer plus datapath.
// Depends on spr_pkg, spr_ctrl and spr_dpath.
//
//  channel | signals                      | transfer when
//  cfg     | cfg_we_i, cfg_data_i         | cfg_we_i high
//  in      | in_valid_i / in_ready_o      | valid and ready high
//  out     | out_valid_o / out_ready_i    | valid and ready high
//
// Each item is accepted with a slot table read, executed with row store
// access, then finished into the output register.
// A result waits in the output register; the next item is accepted meanwhile
// and stalls in its finish cycle only if the previous result is still held.
// Reset is asynchronous; stores hold no reset and need no clearing pass.
module slotted_page_row_store_top import spr_pkg::*; #(
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF,
  parameter int unsigned MAX_SLOTS  = MAX_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  operation_i,
  input  logic [9:0]  slot_id_i,
  input  logic [11:0] row_length_i,
  input  logic [11:0] byte_index_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  input  logic [31:0] link_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [9:0]  new_slot_o,
  output logic [7:0]  read_byte_o,
  output logic [11:0] stored_length_o,
  output logic [9:0]  slot_total_o,
  output logic [11:0] free_bytes_o,
  output logic [31:0] next_link_o,
  output logic [31:0] this_page_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  spr_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  spr_dpath #(.PAGE_BYTES(PAGE_BYTES), .MAX_SLOTS(MAX_SLOTS)) u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .cfg_we_i, .cfg_data_i,
    .operation_i, .slot_id_i, .row_length_i, .byte_index_i, .data_byte_i,
    .last_i, .link_value_i, .status_o, .new_slot_o, .read_byte_o,
    .stored_length_o, .slot_total_o, .free_bytes_o, .next_link_o, .this_page_o
  );

endmodule

// File: sim/slotted_page_row_store_top_test.sv
// Self-checking testbench for slotted_page_row_store_top: directed table, then random runs.
// Depends on spr_pkg and the slotted page RTL; a local page model predicts every result.
module slotted_page_row_store_top_test;
  import spr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PAGE = PAGE_BYTES_DEF;
  localparam int unsigned SLOTS = MAX_SLOTS_DEF;

  typedef struct packed {
    logic [2:0]  op;
    logic [9:0]  slot;
    logic [11:0] len;
    logic [11:0] idx;
    logic [7:0]  data;
    logic        last;
    logic [31:0] link;
  } page_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  nslot;
    logic [7:0]  rbyte;
    logic [11:0] slen;
    logic [9:0]  total;
    logic [11:0] free;
    logic [31:0] next;
    logic [31:0] page;
  } page_rsp_t;

  typedef struct packed {
    page_req_t   req;
    logic        typed;
    logic [2:0]  typed_status;
  } table_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  operation_i = '0;
  logic [9:0]  slot_id_i = '0;
  logic [11:0] row_length_i = '0;
  logic [11:0] byte_index_i = '0;
  logic [7:0]  data_byte_i = '0;
  logic        last_i = 1'b0;
  logic [31:0] link_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [9:0]  new_slot_o;
  logic [7:0]  read_byte_o;
  logic [11:0] stored_length_o;
  logic [9:0]  slot_total_o;
  logic [11:0] free_bytes_o;
  logic [31:0] next_link_o;
  logic [31:0] this_page_o;

  slotted_page_row_store_top uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .in_valid_i, .in_ready_o,
    .operation_i, .slot_id_i, .row_length_i, .byte_index_i, .data_byte_i,
    .last_i, .link_value_i, .out_valid_o, .out_ready_i, .status_o, .new_slot_o,
    .read_byte_o, .stored_length_o, .slot_total_o, .free_bytes_o, .next_link_o,
    .this_page_o
  );

  // page model state
  logic [7:0]  row_mem [PAGE];
  logic [25:0] slot_mem [SLOTS];
  int unsigned slot_cnt, free_start, free_end, next_page, page_id;
  bit          run_busy, run_ok, run_upd;
  int unsigned run_code, run_base, run_cnt, run_len, run_slot;

  page_req_t   stim_q[$];
  page_rsp_t   rsp_q[$];
  bit          typed_q[$];
  logic [2:0]  typed_st_q[$];
  bit          feeding = 1'b0;
  int          errors = 0;
  int          items = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic void clear_page();
    foreach (row_mem[i]) row_mem[i] = '0;
    foreach (slot_mem[i]) slot_mem[i] = '0;
    slot_cnt = 0;
    free_start = HDR_BYTES;
    free_end = PAGE;
    next_page = 32'hFFFF_FFFF;
    run_busy = 0;
    run_ok = 0;
    run_upd = 0;
    run_code = 0;
    run_base = 0;
    run_cnt = 0;
    run_len = 0;
    run_slot = 0;
  endfunction

  function automatic bit slot_live(int unsigned s);
    return s < slot_cnt && s < SLOTS;
  endfunction

  function automatic void open_run(bit upd, int unsigned s, int unsigned len);
    int unsigned off, size;
    off = s < SLOTS ? slot_mem[s][12:0] : 0;
    size = s < SLOTS ? slot_mem[s][25:13] : 0;
    run_busy = 1;
    run_upd = upd;
    run_cnt = 0;
    run_len = len;
    run_slot = s;
    run_base = 0;
    run_code = ST_OK;
    if (!upd) begin
      if (free_start > free_end || len + ENTRY_BYTES > free_end - free_start ||
          slot_cnt >= SLOTS) begin
        run_code = ST_NO_SPACE;
      end else begin
        run_base = free_end - len;
        run_slot = slot_cnt;
      end
    end else if (!slot_live(s)) begin
      run_code = ST_BAD_SLOT;
    end else if (size == 0) begin
      run_code = ST_DELETED;
    end else if (off + size > PAGE || off < free_end) begin
      run_code = ST_BOUNDS;
    end else if (len != size) begin
      run_code = ST_MISMATCH;
    end else begin
      run_base = off;
    end
    run_ok = (run_code == ST_OK);
  endfunction

  // advances the page model by one transfer; returns 1 when a result is due
  function automatic bit page_step(input page_req_t r, output page_rsp_t o);
    int unsigned st, ns, rb, sl, off, size, a;
    bit upd;
    st = 0; ns = 0; rb = 0; sl = 0;
    o = '0;
    if (r.op == OP_INSERT || r.op == OP_UPDATE) begin
      upd = (r.op == OP_UPDATE);
      if (!(run_busy && run_upd == upd)) open_run(upd, r.slot, r.len);
      if (run_ok && run_cnt < run_len) begin
        a = run_base + run_cnt;
        if (a < PAGE) row_mem[a] = r.data;
      end
      if (run_cnt < 13'h1FFF) run_cnt++;
      if (!r.last) return 0;
      run_busy = 0;
      st = run_code;
      if (st == ST_OK && run_cnt < run_len) st = ST_MISMATCH;
      if (upd) begin
        if (slot_live(run_slot)) sl = slot_mem[run_slot][25:13];
      end else if (st == ST_OK) begin
        if (run_slot < SLOTS) slot_mem[run_slot] = {run_len[12:0], run_base[12:0]};
        ns = run_slot;
        sl = run_len;
        slot_cnt = (slot_cnt + 1) & 11'h7FF;
        free_start = (free_start + ENTRY_BYTES) & 13'h1FFF;
        free_end = (free_end - run_len) & 13'h1FFF;
      end
      run_ok = 0;
    end else begin
      run_busy = 0;
      run_ok = 0;
      if (r.op == OP_INIT) begin
        clear_page();
      end else if (r.op == OP_READ || r.op == OP_DELETE) begin
        off = slot_mem[r.slot][12:0];
        size = slot_mem[r.slot][25:13];
        if (!slot_live(r.slot)) begin
          st = ST_BAD_SLOT;
        end else if (size == 0) begin
          st = ST_DELETED;
        end else begin
          sl = size;
          if (r.op == OP_READ) begin
            a = off + r.idx;
            if (r.idx < size && a < PAGE) rb = row_mem[a];
          end else begin
            slot_mem[r.slot] = 26'(off);
          end
        end
      end else if (r.op == OP_LINK) begin
        next_page = r.link;
      end else begin
        return 0;
      end
    end
    o.status = 3'(st);
    o.nslot = 10'(ns);
    o.rbyte = 8'(rb);
    o.slen = 12'(sl);
    o.total = 10'(slot_cnt);
    o.free = free_end >= free_start ? 12'(free_end - free_start) : 12'd0;
    o.next = next_page;
    o.page = page_id;
    return 1;
  endfunction

  // input side: predict on every transfer
  always @(posedge clk_i) begin
    page_rsp_t o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      if (page_step({operation_i, slot_id_i, row_length_i, byte_index_i, data_byte_i,
                     last_i, link_value_i}, o)) rsp_q.push_back(o);
    end
  end

  task automatic cmp(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $realtime, name, e, a);
      errors++;
    end
  endtask

  // output side
  always @(posedge clk_i) begin
    page_rsp_t e;
    logic [2:0] st;
    bit typed;
    logic [2:0] typed_st;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rsp_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual status %0d", $realtime,
                 status_o);
        errors++;
      end else begin
        e = rsp_q.pop_front();
        st = e.status;
        if (typed_q.size() != 0) begin
          typed = typed_q.pop_front();
          typed_st = typed_st_q.pop_front();
          if (typed) st = typed_st;
        end
        cmp("status", st, status_o);
        cmp("new_slot", e.nslot, new_slot_o);
        cmp("read_byte", e.rbyte, read_byte_o);
        cmp("stored_length", e.slen, stored_length_o);
        cmp("slot_total", e.total, slot_total_o);
        cmp("free_bytes", e.free, free_bytes_o);
        cmp("next_link", e.next, next_link_o);
        cmp("this_page", e.page, this_page_o);
      end
    end
  end

  // receiver stall pattern
  initial begin
    int mode, left, tick;
    mode = 0; left = 0; tick = 0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(8, 80);
      end
      left--;
      tick++;
      case (mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 9) < 7);
        2: out_ready_i <= ($urandom_range(0, 9) < 2);
        default: out_ready_i <= (tick % 4 == 0);
      endcase
    end
  end

  // sender: bursts with gaps
  initial begin
    page_req_t r;
    int burst, gap;
    burst = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (stim_q.size() == 0) begin
        feeding = 0;
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        feeding = 1;
        if (burst == 0) begin
          burst = $urandom_range(1, 30);
          gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
          if (gap > 0) begin
            in_valid_i <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
        end
        r = stim_q.pop_front();
        in_valid_i   <= 1'b1;
        operation_i  <= r.op;
        slot_id_i    <= r.slot;
        row_length_i <= r.len;
        byte_index_i <= r.idx;
        data_byte_i  <= r.data;
        last_i       <= r.last;
        link_value_i <= r.link;
        @(posedge clk_i);
        while (!in_ready_o) @(posedge clk_i);
        burst--;
      end
    end
  end

  task automatic push(input logic [2:0] op, input int unsigned s, input int unsigned len,
                      input int unsigned idx, input int unsigned d, input bit last,
                      input logic [31:0] link);
    stim_q.push_back({op, s[9:0], len[11:0], idx[11:0], d[7:0], last, link});
    items++;
  endtask

  // byte run of n items with random lengths; bytes beyond the run length are not stored
  task automatic push_run(input logic [2:0] op, input int unsigned s, input int unsigned len,
                          input int unsigned n);
    for (int i = 0; i < n; i++)
      push(op, s, $urandom_range(0, 4095), $urandom, $urandom_range(0, 255), i == n - 1,
           $urandom);
  endtask

  task automatic settle();
    while (stim_q.size() != 0 || feeding || rsp_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_page_id(input logic [31:0] v);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    page_id = v;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_group();
    int k, s, len, n;
    k = $urandom_range(0, 99);
    s = slot_cnt > 0 ? $urandom_range(0, slot_cnt - 1) : 0;
    if (k < 35) begin
      len = $urandom_range(0, 9) == 0 ? $urandom_range(32, 300) : $urandom_range(0, 12);
      n = len == 0 ? 1 : len;
      if ($urandom_range(0, 9) == 0) n += $urandom_range(1, 3);
      push_run(OP_INSERT, $urandom, len, 0);
      for (int i = 0; i < n; i++)
        push(OP_INSERT, $urandom, len, $urandom, $urandom, i == n - 1, $urandom);
    end else if (k < 55) begin
      len = slot_mem[s][25:13];
      push(OP_READ, s, $urandom, ($urandom_range(0, 5) == 0 || len == 0) ?
           $urandom_range(0, 4095) : $urandom_range(0, len - 1), $urandom, $urandom, $urandom);
    end else if (k < 62) begin
      push(OP_DELETE, s, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (k < 77) begin
      len = slot_mem[s][25:13];
      n = len == 0 ? 1 : len;
      for (int i = 0; i < n; i++)
        push(OP_UPDATE, s, len, $urandom, $urandom, i == n - 1, $urandom);
    end else if (k < 82) begin
      push(OP_LINK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (k < 84) begin
      push(OP_INIT, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (k < 92) begin
      // broken run: random header, cut short or left open
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++)
        push($urandom_range(0, 1) ? OP_INSERT : OP_UPDATE, $urandom, $urandom, $urandom,
             $urandom, $urandom_range(0, 3) == 0, $urandom);
    end else if (k < 96) begin
      push($urandom_range(6, 7), $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      push($urandom_range(0, 1) ? OP_READ : OP_DELETE, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom);
    end
  endtask

  table_row_t dir_tbl[$];

  task automatic row(input logic [2:0] op, input int unsigned s, input int unsigned len,
                     input int unsigned idx, input int unsigned d, input bit last,
                     input logic [31:0] link, input bit typed, input logic [2:0] st);
    dir_tbl.push_back({op, s[9:0], len[11:0], idx[11:0], d[7:0], last, link, typed, st});
  endtask

  initial begin
    logic [31:0] ids [4];
    clear_page();
    page_id = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_page_id(32'h0000_0000);

    row(OP_READ,   0,    0,    0,    0,    0, 0, 1, ST_BAD_SLOT);
    row(OP_DELETE, 1023, 4095, 4095, 255,  1, 0, 1, ST_BAD_SLOT);
    row(OP_INSERT, 0,    0,    0,    8'h77, 1, 0, 1, ST_OK);
    row(OP_READ,   0,    0,    0,    0,    0, 0, 1, ST_DELETED);
    row(OP_INSERT, 0,    3,    0,    8'h00, 0, 0, 0, 0);
    row(OP_INSERT, 0,    3,    0,    8'hFF, 0, 0, 0, 0);
    row(OP_INSERT, 0,    3,    0,    8'h5A, 1, 0, 1, ST_OK);
    row(OP_READ,   1,    0,    0,    0,    0, 0, 0, 0);
    row(OP_READ,   1,    0,    2,    0,    0, 0, 0, 0);
    row(OP_READ,   1,    0,    4095, 0,    0, 0, 0, 0);
    row(OP_UPDATE, 1,    2,    0,    8'h11, 1, 0, 1, ST_MISMATCH);
    row(OP_UPDATE, 1,    3,    0,    8'hA5, 0, 0, 0, 0);
    row(OP_UPDATE, 1,    3,    0,    8'h3C, 0, 0, 0, 0);
    row(OP_UPDATE, 1,    3,    0,    8'hC3, 1, 0, 1, ST_OK);
    row(OP_UPDATE, 0,    0,    0,    0,    1, 0, 1, ST_DELETED);
    row(OP_UPDATE, 1023, 3,    0,    0,    1, 0, 1, ST_BAD_SLOT);
    row(OP_INSERT, 0,    4068, 0,    0,    1, 0, 1, ST_NO_SPACE);
    row(OP_INSERT, 0,    2,    0,    8'h42, 1, 0, 1, ST_MISMATCH);
    row(OP_INSERT, 0,    1,    0,    8'h99, 0, 0, 0, 0);
    row(OP_LINK,   0,    0,    0,    0,    0, 32'hFFFF_FFFF, 0, 0);
    row(OP_INSERT, 0,    1,    0,    8'hE1, 0, 0, 0, 0);
    row(OP_INSERT, 0,    1,    0,    8'hE2, 1, 0, 1, ST_OK);
    row(OP_DELETE, 1,    0,    0,    0,    0, 0, 1, ST_OK);
    row(6,         1023, 4095, 4095, 255,  1, 32'hFFFF_FFFF, 0, 0);
    row(OP_INIT,   0,    0,    0,    0,    0, 0, 0, 0);
    row(OP_LINK,   0,    0,    0,    0,    0, 0, 0, 0);

    foreach (dir_tbl[i]) begin
      stim_q.push_back(dir_tbl[i].req);
      // only rows that produce a result carry a status slot in the typed queue
      if (dir_tbl[i].req.op inside {OP_INIT, OP_READ, OP_DELETE, OP_LINK} ||
          (dir_tbl[i].req.op inside {OP_INSERT, OP_UPDATE} && dir_tbl[i].req.last)) begin
        typed_q.push_back(dir_tbl[i].typed);
        typed_st_q.push_back(dir_tbl[i].typed_status);
      end
    end
    settle();
    typed_q.delete();
    typed_st_q.delete();

    ids[0] = 32'hFFFF_FFFF;
    ids[1] = $urandom;
    ids[2] = 32'h8000_0000;
    ids[3] = $urandom;
    items = 0;
    for (int p = 0; p < 4; p++) begin
      set_page_id(ids[p]);
      while (items < (p + 1) * 500) begin
        while (stim_q.size() > 8) @(posedge clk_i);
        random_group();
      end
      settle();
    end

    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/spr_pkg.sv
hw/rtl/spr_ctrl.sv
hw/rtl/spr_dpath.sv
hw/rtl/slotted_page_row_store_top.sv
sim/slotted_page_row_store_top_test.sv
